FILE: src/tcs_pkg.sv
// Shared types and constants for the text character statistics block.
// No dependencies.
`default_nettype none

package tcs_pkg;

	localparam int LETTER_BINS  = 26;
	localparam int LETTER_IDX_W = $clog2(LETTER_BINS);
	localparam int STAT_IDX_W   = 6;
	localparam int STAT_VALUE_W = 48;
	localparam int VALUE_W      = 32;
	localparam int NUM_STATS    = 35;

	typedef logic [STAT_IDX_W-1:0]   stat_idx_t;
	typedef logic [LETTER_IDX_W-1:0] letter_idx_t;

	// report order
	localparam stat_idx_t STAT_TOTAL     = 6'd0;
	localparam stat_idx_t STAT_LETTERS   = 6'd1;
	localparam stat_idx_t STAT_SPACE     = 6'd2;
	localparam stat_idx_t STAT_DIGITS    = 6'd3;
	localparam stat_idx_t STAT_OTHER     = 6'd4;
	localparam stat_idx_t STAT_UPPER     = 6'd5;
	localparam stat_idx_t STAT_LOWER     = 6'd6;
	localparam stat_idx_t STAT_INT_COUNT = 6'd7;
	localparam stat_idx_t STAT_INT_SUM   = 6'd8;
	localparam stat_idx_t STAT_HIST_BASE = 6'd9;
	localparam stat_idx_t STAT_LAST      = 6'(NUM_STATS - 1);

	// class counter slots
	localparam int CLS_LETTER = 0;
	localparam int CLS_SPACE  = 1;
	localparam int CLS_DIGIT  = 2;
	localparam int CLS_OTHER  = 3;
	localparam int CASE_UPPER = 0;
	localparam int CASE_LOWER = 1;

	// character codes
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef struct packed {
		logic        is_digit;
		logic        is_upper;
		logic        is_lower;
		logic        is_space;
		logic        is_other;
		logic [3:0]  digit;
		letter_idx_t letter;
	} byte_class_t;

endpackage

`default_nettype wire

FILE: src/tcs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module tcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 26
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: src/text_character_statistics.sv
// Top level of the text character statistics block: classifier, counters,
// letter histogram RAM and report sequencer. Depends on tcs_pkg and tcs_ram.
`default_nettype none

//  channel | signals                                  | dir | contents
//  --------+------------------------------------------+-----+---------------------------
//  input   | in_valid, in_ready, data_byte,           | in  | one text byte per request,
//          | end_of_text                              |     | end_of_text on the last
//  output  | out_valid, out_ready, stat_index,        | out | 35 statistics per text,
//          | stat_value, last_stat                    |     | last_stat on index 34
//
//  One byte per cycle while a text streams in; the letter histogram RAM is read
//  at accept and written back in the cycle after, with a bypass of the last write.
//  The byte marked end_of_text is followed by drain, run flush and the RAM read,
//  then 35 report requests, one per cycle that out_ready allows; in_ready is
//  low from that byte until the last statistic is taken.
//  Reset (arst_n low) clears every counter and the histogram valid bits at once.

module text_character_statistics #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [7:0]                         data_byte,
	input  wire logic                               end_of_text,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic      [tcs_pkg::STAT_IDX_W-1:0]     stat_index,
	output logic      [tcs_pkg::STAT_VALUE_W-1:0]   stat_value,
	output logic                                    last_stat
);

	import tcs_pkg::*;

	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_FLUSH,
		ST_REPORT
	} state_t;

	function automatic count_t bump(input count_t c);
		return (&c) ? c : c + 1'b1;
	endfunction

	state_t state_q;

	// counters
	count_t                   total_q;
	count_t                   class_q [4];
	count_t                   case_q  [2];
	count_t                   int_count_q;
	logic [STAT_VALUE_W-1:0]  int_sum_q;
	logic                     in_number_q;
	logic [VALUE_W-1:0]       number_q;
	logic [LETTER_BINS-1:0]   hist_vld_q;

	// update stage
	logic        v_s1;
	byte_class_t cls_s1;

	// last histogram write, for the bypass
	logic        wr_valid_q;
	letter_idx_t wr_addr_q;
	count_t      wr_data_q;

	// report fetch
	stat_idx_t   fetch_idx_q;
	logic        fetch_done_q;
	logic        f_valid_s1;
	stat_idx_t   f_idx_s1;
	logic        f_hvld_s1;

	// output register
	logic                    out_valid_q;
	stat_idx_t               stat_index_q;
	logic [STAT_VALUE_W-1:0] stat_value_q;
	logic                    last_stat_q;

	byte_class_t in_cls;
	logic        accept;
	logic        issue;
	logic        f_adv;
	letter_idx_t fetch_addr;
	letter_idx_t ram_rd_addr;
	count_t      ram_rd_data;
	count_t      hist_old;
	count_t      hist_new;
	logic        hist_wr;
	logic [VALUE_W+3:0]      nv_mul;
	logic [VALUE_W-1:0]      nv_next;
	logic [STAT_VALUE_W:0]   sum_add;
	logic [STAT_VALUE_W-1:0] sum_next;
	logic [STAT_VALUE_W-1:0] f_value;

	assign in_ready   = (state_q == ST_RUN);
	assign accept     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign stat_index = stat_index_q;
	assign stat_value = stat_value_q;
	assign last_stat  = last_stat_q;

	// byte classifier
	always_comb begin
		in_cls          = '0;
		in_cls.is_digit = data_byte inside {[CH_0:CH_9]};
		in_cls.is_upper = data_byte inside {[CH_UA:CH_UZ]};
		in_cls.is_lower = data_byte inside {[CH_LA:CH_LZ]};
		in_cls.is_space = data_byte inside {CH_SPACE, [CH_TAB:CH_CR]};
		in_cls.is_other = !(in_cls.is_digit || in_cls.is_upper ||
			in_cls.is_lower || in_cls.is_space);
		in_cls.digit    = 4'(data_byte - CH_0);
		if (in_cls.is_upper) begin
			in_cls.letter = LETTER_IDX_W'(data_byte - CH_UA);
		end else if (in_cls.is_lower) begin
			in_cls.letter = LETTER_IDX_W'(data_byte - CH_LA);
		end
	end

	// histogram read-modify-write; bypass covers the write that lands on the
	// same edge as the read of the next byte
	assign hist_wr  = v_s1 && (cls_s1.is_upper || cls_s1.is_lower);
	assign hist_old = (wr_valid_q && (wr_addr_q == cls_s1.letter)) ? wr_data_q :
		(hist_vld_q[cls_s1.letter] ? ram_rd_data : '0);
	assign hist_new = bump(hist_old);

	// digit run arithmetic: value*10 + digit, then run value into the sum
	assign nv_mul   = ({4'b0, number_q} << 3) + ({4'b0, number_q} << 1) +
		(VALUE_W+4)'(cls_s1.digit);
	assign nv_next  = (|nv_mul[VALUE_W+3:VALUE_W]) ? '1 : nv_mul[VALUE_W-1:0];
	assign sum_add  = {1'b0, int_sum_q} + (STAT_VALUE_W+1)'(number_q);
	assign sum_next = sum_add[STAT_VALUE_W] ? '1 : sum_add[STAT_VALUE_W-1:0];

	// report fetch: one statistic per cycle, stalls with the output register
	assign f_adv      = f_valid_s1 && (!out_valid_q || out_ready);
	assign issue      = (state_q == ST_REPORT) && !fetch_done_q && (!f_valid_s1 || f_adv);
	assign fetch_addr = (fetch_idx_q >= STAT_HIST_BASE) ?
		LETTER_IDX_W'(fetch_idx_q - STAT_HIST_BASE) : '0;
	assign ram_rd_addr = (state_q == ST_REPORT) ? fetch_addr : in_cls.letter;

	always_comb begin
		case (f_idx_s1)
			STAT_TOTAL:     f_value = STAT_VALUE_W'(total_q);
			STAT_LETTERS:   f_value = STAT_VALUE_W'(class_q[CLS_LETTER]);
			STAT_SPACE:     f_value = STAT_VALUE_W'(class_q[CLS_SPACE]);
			STAT_DIGITS:    f_value = STAT_VALUE_W'(class_q[CLS_DIGIT]);
			STAT_OTHER:     f_value = STAT_VALUE_W'(class_q[CLS_OTHER]);
			STAT_UPPER:     f_value = STAT_VALUE_W'(case_q[CASE_UPPER]);
			STAT_LOWER:     f_value = STAT_VALUE_W'(case_q[CASE_LOWER]);
			STAT_INT_COUNT: f_value = STAT_VALUE_W'(int_count_q);
			STAT_INT_SUM:   f_value = int_sum_q;
			default:        f_value = f_hvld_s1 ? STAT_VALUE_W'(ram_rd_data) : '0;
		endcase
	end

	tcs_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (LETTER_BINS)
	) u_hist_ram (
		.clk     (clk),
		.wr_en   (hist_wr),
		.wr_addr (cls_s1.letter),
		.wr_data (hist_new),
		.rd_en   (accept || issue),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			total_q      <= '0;
			class_q      <= '{default: '0};
			case_q       <= '{default: '0};
			int_count_q  <= '0;
			int_sum_q    <= '0;
			in_number_q  <= 1'b0;
			number_q     <= '0;
			hist_vld_q   <= '0;
			v_s1         <= 1'b0;
			cls_s1       <= '0;
			wr_valid_q   <= 1'b0;
			wr_addr_q    <= '0;
			wr_data_q    <= '0;
			fetch_idx_q  <= '0;
			fetch_done_q <= 1'b0;
			f_valid_s1   <= 1'b0;
			f_idx_s1     <= '0;
			f_hvld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
			stat_index_q <= '0;
			stat_value_q <= '0;
			last_stat_q  <= 1'b0;
		end else begin
			v_s1       <= accept;
			wr_valid_q <= hist_wr;
			if (accept) begin
				cls_s1 <= in_cls;
			end

			// counter update, in the cycle after accept
			if (v_s1) begin
				total_q <= bump(total_q);
				if (cls_s1.is_digit) begin
					class_q[CLS_DIGIT] <= bump(class_q[CLS_DIGIT]);
					if (!in_number_q) begin
						in_number_q <= 1'b1;
						int_count_q <= bump(int_count_q);
						number_q    <= VALUE_W'(cls_s1.digit);
					end else begin
						number_q <= nv_next;
					end
				end else begin
					if (in_number_q) begin
						int_sum_q   <= sum_next;
						in_number_q <= 1'b0;
						number_q    <= '0;
					end
					if (cls_s1.is_upper) begin
						class_q[CLS_LETTER] <= bump(class_q[CLS_LETTER]);
						case_q[CASE_UPPER]  <= bump(case_q[CASE_UPPER]);
					end
					if (cls_s1.is_lower) begin
						class_q[CLS_LETTER] <= bump(class_q[CLS_LETTER]);
						case_q[CASE_LOWER]  <= bump(case_q[CASE_LOWER]);
					end
					if (cls_s1.is_space) begin
						class_q[CLS_SPACE] <= bump(class_q[CLS_SPACE]);
					end
					if (cls_s1.is_other) begin
						class_q[CLS_OTHER] <= bump(class_q[CLS_OTHER]);
					end
				end
				if (hist_wr) begin
					hist_vld_q[cls_s1.letter] <= 1'b1;
					wr_addr_q                 <= cls_s1.letter;
					wr_data_q                 <= hist_new;
				end
			end

			// report fetch and output register
			if (issue) begin
				f_valid_s1  <= 1'b1;
				f_idx_s1    <= fetch_idx_q;
				f_hvld_s1   <= hist_vld_q[fetch_addr];
				fetch_idx_q <= fetch_idx_q + 1'b1;
				if (fetch_idx_q == STAT_LAST) begin
					fetch_done_q <= 1'b1;
				end
			end else if (f_adv) begin
				f_valid_s1 <= 1'b0;
			end

			if (f_adv) begin
				out_valid_q  <= 1'b1;
				stat_index_q <= f_idx_s1;
				stat_value_q <= f_value;
				last_stat_q  <= (f_idx_s1 == STAT_LAST);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_RUN: begin
					if (accept && end_of_text) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					// wait for the last byte to commit, then close an open run
					if (!v_s1) begin
						if (in_number_q) begin
							int_sum_q   <= sum_next;
							in_number_q <= 1'b0;
							number_q    <= '0;
						end
						fetch_idx_q  <= '0;
						fetch_done_q <= 1'b0;
						state_q      <= ST_REPORT;
					end
				end
				ST_REPORT: begin
					if (out_valid_q && out_ready && last_stat_q) begin
						total_q     <= '0;
						class_q     <= '{default: '0};
						case_q      <= '{default: '0};
						int_count_q <= '0;
						int_sum_q   <= '0;
						in_number_q <= 1'b0;
						number_q    <= '0;
						hist_vld_q  <= '0;
						state_q     <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for text_character_statistics: drives byte streams,
// predicts the 35-entry report of each text and checks every statistic.
// Depends on tcs_pkg and the text_character_statistics RTL.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tcs_pkg::*;

	// counter width the block is built with; every tally saturates here, the integer sum at 48 bits
	localparam int          CNT_W        = 32;
	localparam logic [47:0] COUNT_MAX    = 48'((64'd1 << CNT_W) - 1);
	localparam logic [47:0] RUN_MAX      = 48'hFFFF_FFFF;
	localparam logic [47:0] SUM_MAX      = 48'hFFFF_FFFF_FFFF;
	// quiet cycles tolerated: receiver hold-off plus gaps and drain, several times over
	localparam int          STALL_LIMIT  = 5000;
	localparam int          DRAIN_CYCLES = 20;
	localparam int          MAX_REPORTED = 10;

	typedef struct {
		stat_idx_t   idx;
		logic [47:0] value;
		logic        last;
	} stat_rec_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte   = 8'h00;
	logic        end_of_text = 1'b0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [STAT_IDX_W-1:0]   stat_index;
	logic [STAT_VALUE_W-1:0] stat_value;
	logic        last_stat;

	// shadow copy of the block's statistics state
	logic [47:0] byte_total;
	logic [47:0] class_tally [4];
	logic [47:0] case_tally [2];
	logic [47:0] letter_tally [LETTER_BINS];
	logic        run_open;
	logic [47:0] run_value;
	logic [47:0] run_count;
	logic [47:0] run_sum;

	stat_rec_t   pending_stats [$];
	int          mismatches  = 0;
	int          quiet_count = 0;

	// traffic shaping knobs, owned by the test tasks
	bit          tx_steady   = 1'b0;
	bit          rx_steady   = 1'b0;
	int          hold_cycles = 0;

	text_character_statistics #(.COUNT_BITS(CNT_W)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.end_of_text(end_of_text),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.stat_index (stat_index),
		.stat_value (stat_value),
		.last_stat  (last_stat)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Statistics predictor
	// ------------------------------------------------------------------

	function automatic logic [47:0] sat_inc(input logic [47:0] c);
		return (c < COUNT_MAX) ? c + 48'd1 : c;
	endfunction

	function automatic void clear_stats();
		byte_total = '0;
		foreach (class_tally[i]) class_tally[i] = '0;
		foreach (case_tally[i]) case_tally[i] = '0;
		foreach (letter_tally[i]) letter_tally[i] = '0;
		run_open  = 1'b0;
		run_value = '0;
		run_count = '0;
		run_sum   = '0;
	endfunction

	// a digit run ends: its value goes into the (saturating) integer sum
	function automatic void close_number_run();
		logic [48:0] s;
		if (run_open) begin
			s = {1'b0, run_sum} + {1'b0, run_value};
			run_sum   = (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[47:0];
			run_open  = 1'b0;
			run_value = '0;
		end
	endfunction

	// queue the 35 statistics in report order, then start a fresh text
	function automatic void emit_report();
		stat_rec_t   rec;
		stat_idx_t   idx;
		logic [47:0] v;
		for (int k = 0; k < NUM_STATS; k++) begin
			idx = stat_idx_t'(k);
			case (idx)
				STAT_TOTAL:     v = byte_total;
				STAT_LETTERS:   v = class_tally[CLS_LETTER];
				STAT_SPACE:     v = class_tally[CLS_SPACE];
				STAT_DIGITS:    v = class_tally[CLS_DIGIT];
				STAT_OTHER:     v = class_tally[CLS_OTHER];
				STAT_UPPER:     v = case_tally[CASE_UPPER];
				STAT_LOWER:     v = case_tally[CASE_LOWER];
				STAT_INT_COUNT: v = run_count;
				STAT_INT_SUM:   v = run_sum;
				default:        v = letter_tally[k - int'(STAT_HIST_BASE)];
			endcase
			rec.idx   = idx;
			rec.value = v;
			rec.last  = (idx == STAT_LAST);
			pending_stats.push_back(rec);
		end
		clear_stats();
	endfunction

	function automatic void tally_byte(input logic [7:0] b, input logic eot);
		logic [63:0] v;
		byte_total = sat_inc(byte_total);
		if (b >= CH_0 && b <= CH_9) begin
			class_tally[CLS_DIGIT] = sat_inc(class_tally[CLS_DIGIT]);
			if (!run_open) begin
				run_open  = 1'b1;
				run_count = sat_inc(run_count);
				run_value = 48'(b - CH_0);
			end else begin
				v = 64'(run_value) * 64'd10 + 64'(b - CH_0);
				run_value = (v > 64'(RUN_MAX)) ? RUN_MAX : v[47:0];
			end
		end else begin
			// any non-digit ends the run before being classified itself
			close_number_run();
			if (b >= CH_UA && b <= CH_UZ) begin
				class_tally[CLS_LETTER] = sat_inc(class_tally[CLS_LETTER]);
				case_tally[CASE_UPPER]  = sat_inc(case_tally[CASE_UPPER]);
				letter_tally[b - CH_UA] = sat_inc(letter_tally[b - CH_UA]);
			end else if (b >= CH_LA && b <= CH_LZ) begin
				class_tally[CLS_LETTER] = sat_inc(class_tally[CLS_LETTER]);
				case_tally[CASE_LOWER]  = sat_inc(case_tally[CASE_LOWER]);
				letter_tally[b - CH_LA] = sat_inc(letter_tally[b - CH_LA]);
			end else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
				class_tally[CLS_SPACE] = sat_inc(class_tally[CLS_SPACE]);
			end else begin
				class_tally[CLS_OTHER] = sat_inc(class_tally[CLS_OTHER]);
			end
		end
		if (eot) begin
			// a run still open at the final byte is flushed into the sum
			close_number_run();
			emit_report();
		end
	endfunction

	// ------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------

	// Offers one byte and returns in the step it is taken. in_valid stays
	// high across back-to-back requests; it drops only for a random gap or in wait_for_reports.
	task automatic send_byte(input logic [7:0] b, input logic eot);
		int gap;
		if (!tx_steady && $urandom_range(99) < 17) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		data_byte   <= b;
		end_of_text <= eot;
		do @(posedge clk); while (in_ready !== 1'b1);
		tally_byte(b, eot);
	endtask

	task automatic send_text(input logic [7:0] txt [$]);
		foreach (txt[i])
			send_byte(txt[i], i == txt.size() - 1);
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	// sender goes quiet until the whole report has been taken
	task automatic wait_for_reports();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_stats.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls, or a counted hold-off when a test asks
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles--;
		end else begin
			out_ready <= rx_steady || ($urandom_range(99) >= 17);
		end
	end

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------

	task automatic note_mismatch(input string what, input logic [47:0] want,
			input logic [47:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTED)
			$display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin
		stat_rec_t exp_rec;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_stats.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTED)
					$display("[%0t] statistic %0d with no report pending",
						$realtime, stat_index);
			end else begin
				exp_rec = pending_stats.pop_front();
				if (stat_index !== exp_rec.idx)
					note_mismatch("stat_index", 48'(exp_rec.idx), 48'(stat_index));
				if (stat_value !== exp_rec.value)
					note_mismatch($sformatf("stat_value[%0d]", exp_rec.idx),
						exp_rec.value, stat_value);
				if (last_stat !== exp_rec.last)
					note_mismatch($sformatf("last_stat[%0d]", exp_rec.idx),
						48'(exp_rec.last), 48'(last_stat));
			end
		end
	end

	// watchdog: a long stretch with no request taken on either side is a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
				quiet_count <= 0;
			else
				quiet_count <= quiet_count + 1;
			if (quiet_count >= STALL_LIMIT) begin
				$display("[%0t] no progress for %0d cycles", $realtime, STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Class edges: control bytes, 0x7F, high-half bytes, the characters just
	// outside each range, all six white space codes, both letter cases at
	// A and Z, and a digit run left open on the final byte.
	task automatic test_class_boundaries();
		logic [7:0] txt [$];
		txt = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h2F, 8'h3A, 8'h40, 8'h5B,
			8'h60, 8'h7B, 8'h08, 8'h0E, 8'h20, 8'h09, 8'h0A, 8'h0B,
			8'h0C, 8'h0D, 8'h41, 8'h5A, 8'h61, 8'h7A, 8'h30, 8'h39};
		send_text(txt);
		// one-byte texts: a lone digit run flushes, a lone letter reports
		send_string("7");
		send_string("Q");
	endtask

	// Digit runs: the largest 32-bit value, one past it, a long run that
	// pins the value, leading zeros, and a run closed by a letter.
	task automatic test_long_numbers();
		send_string("4294967295 4294967296x99999999999999,0 00012q007");
	endtask

	// Text-like streams: words, numbers, white space, punctuation, plus
	// raw bytes over the whole range as noise.
	task automatic test_random_texts();
		logic [7:0] txt [$];
		int         sent;
		int         len;
		int         n;
		sent = 0;
		while (sent < 240) begin
			txt.delete();
			len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 40);
			while (txt.size() < len) begin
				case ($urandom_range(7))
					0, 1, 2: begin
						n = $urandom_range(1, 8);
						repeat (n)
							txt.push_back(8'(($urandom_range(1) ? CH_UA : CH_LA) +
								$urandom_range(25)));
					end
					3, 4: begin
						n = ($urandom_range(7) == 0) ? $urandom_range(10, 14) :
							$urandom_range(1, 4);
						repeat (n) txt.push_back(8'(CH_0 + $urandom_range(9)));
					end
					5: txt.push_back($urandom_range(1) ? CH_SPACE :
						8'(CH_TAB + $urandom_range(4)));
					6: txt.push_back(8'(8'h21 + $urandom_range(14)));
					default: txt.push_back(8'($urandom_range(255)));
				endcase
			end
			while (txt.size() > len) void'(txt.pop_back());
			send_text(txt);
			sent += txt.size();
		end
	endtask

	// Receiver holds off while the sender keeps offering the next text, so
	// the report backs up and in_ready stays low on the waiting request.
	task automatic test_output_backpressure();
		hold_cycles = 300;
		send_string("Fill 12 up");
		send_string("next 345 text");
		send_string("Z9");
	endtask

	// Sender idles between texts until every statistic has drained.
	task automatic test_drain_between_texts();
		send_string("alpha 1 beta 22");
		wait_for_reports();
		send_string("Gamma\t333\n");
		wait_for_reports();
		send_string("5");
	endtask

	// Pinned runs (each 2^32-1) separated by commas, with both sides flat
	// out through the text and its whole report.
	task automatic test_steady_stream();
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		repeat (4) begin
			repeat (10) send_byte(CH_9, 1'b0);
			send_byte(8'h2C, 1'b0);
		end
		send_byte(8'h78, 1'b1);
		wait_for_reports();
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		clear_stats();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_class_boundaries();
		test_long_numbers();
		test_random_texts();
		test_output_backpressure();
		test_drain_between_texts();
		test_steady_stream();

		in_valid <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_stats.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
